[rtl/core/mnet_pkg.sv]
// Shared types, constants and helpers for the MIDI note event tracker.
// No dependencies; used by the controller, datapath and top level.
`default_nettype none

package mnet_pkg;

  localparam int NUM_KEYS_DEF = 128;

  localparam int BYTE_W = 8;
  localparam int VEL_W  = 7;
  localparam int KEY_W  = 7;

  // upper nibble of a status byte
  localparam logic [3:0] KIND_NOTE_OFF = 4'h8;
  localparam logic [3:0] KIND_NOTE_ON  = 4'h9;
  localparam logic [3:0] KIND_CONTROL  = 4'hB;

  localparam logic [VEL_W-1:0] THRESH_RESET = 7'd64;

  // input item selector carried on tuser
  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_READ = 1'b1;

  // controller to datapath commands
  typedef struct packed {
    logic byte_en;   // take one MIDI byte
    logic rd_start;  // launch velocity memory read for a key
    logic rd_done;   // resolve the read, update maps, load output
  } mnet_cmd_t;

  function automatic logic [VEL_W-1:0] sat7(input logic [BYTE_W-1:0] v);
    sat7 = v[BYTE_W-1] ? {VEL_W{1'b1}} : v[VEL_W-1:0];
  endfunction

endpackage

`default_nettype wire

[rtl/core/mnet_ctrl.sv]
// Controller for the MIDI note event tracker: handshakes and sequencing.
// Depends on mnet_pkg; drives commands into mnet_dp.
`default_nettype none

module mnet_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic              action,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output mnet_pkg::mnet_cmd_t    cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_LOOK = 1'b1;

  logic state;
  logic state_next;
  logic out_valid;
  logic accept;

  // an input may enter while a result waits only if that result leaves now
  assign s_tready = (state == ST_IDLE) && (!out_valid || m_tready);
  assign accept   = s_tvalid && s_tready;
  assign m_tvalid = out_valid;

  always_comb begin
    state_next   = state;
    cmd.byte_en  = 1'b0;
    cmd.rd_start = 1'b0;
    cmd.rd_done  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (action == mnet_pkg::ACT_READ) begin
            cmd.rd_start = 1'b1;
            state_next   = ST_LOOK;
          end else begin
            cmd.byte_en = 1'b1;
          end
        end
      end
      ST_LOOK: begin
        cmd.rd_done = 1'b1;
        state_next  = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.rd_done) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/mnet_dp.sv]
// Datapath for the MIDI note event tracker: byte grouping, key maps,
// velocity memory, pedal level and output register. Depends on mnet_pkg.
`default_nettype none

module mnet_dp #(
  parameter int NUM_KEYS = mnet_pkg::NUM_KEYS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire mnet_pkg::mnet_cmd_t            cmd,
  input  wire logic                           cfg_we,
  input  wire logic [mnet_pkg::VEL_W-1:0]     cfg_wdata,
  input  wire logic [mnet_pkg::BYTE_W-1:0]    midi_byte,
  input  wire logic [mnet_pkg::KEY_W-1:0]     key,
  output logic      [mnet_pkg::VEL_W-1:0]     velocity,
  output logic                                released,
  output logic      [mnet_pkg::VEL_W-1:0]     pedal_level
);

  localparam int KW = $clog2(NUM_KEYS);
  localparam int BW = mnet_pkg::BYTE_W;
  localparam int VW = mnet_pkg::VEL_W;
  localparam logic [BW:0] NK = (BW+1)'(NUM_KEYS);

  // control state
  logic [1:0]          cnt, cnt_next;
  logic [BW-1:0]       last_status, last_status_next;
  logic [VW-1:0]       pedal, pedal_next;
  logic [VW-1:0]       thresh;
  logic [NUM_KEYS-1:0] rel_map, rel_map_next;
  logic [NUM_KEYS-1:0] sus_map, sus_map_next;
  logic [NUM_KEYS-1:0] vel_valid, vel_valid_next;

  // payload
  logic [BW-1:0]       pb0, pb0_next;
  logic [BW-1:0]       pb1, pb1_next;
  logic [VW-1:0]       vel_mem [NUM_KEYS];
  logic [VW-1:0]       rd_q;
  logic [mnet_pkg::KEY_W-1:0] rkey;

  logic                mem_we;
  logic [KW-1:0]       mem_wa;
  logic [VW-1:0]       mem_wd;
  logic [VW-1:0]       new_pedal;
  logic [3:0]          kind;
  logic [KW-1:0]       msg_idx;
  logic                msg_in_range;
  logic [KW-1:0]       rd_idx;
  logic                rd_in_range;
  logic [VW-1:0]       rd_vel;
  logic                rd_rel;

  assign kind         = pb0[BW-1 -: 4];
  assign new_pedal    = mnet_pkg::sat7(midi_byte);
  assign msg_idx      = pb1[KW-1:0];
  assign msg_in_range = {1'b0, pb1} < NK;
  assign rd_idx       = rkey[KW-1:0];
  assign rd_in_range  = {{(BW+1-mnet_pkg::KEY_W){1'b0}}, rkey} < NK;

  always_comb begin
    cnt_next         = cnt;
    last_status_next = last_status;
    pb0_next         = pb0;
    pb1_next         = pb1;
    pedal_next       = pedal;
    rel_map_next     = rel_map;
    sus_map_next     = sus_map;
    vel_valid_next   = vel_valid;
    mem_we           = 1'b0;
    mem_wa           = msg_idx;
    mem_wd           = new_pedal;
    rd_vel           = '0;
    rd_rel           = 1'b0;

    if (cmd.byte_en) begin
      priority if (cnt == 2'd0 && !midi_byte[BW-1]) begin
        // running status: reuse last status, this byte is the key
        pb0_next = last_status;
        pb1_next = midi_byte;
        cnt_next = 2'd2;
      end else if (cnt == 2'd2) begin
        cnt_next         = 2'd0;
        last_status_next = pb0;
        if (kind == mnet_pkg::KIND_CONTROL) begin
          if (pedal >= thresh && new_pedal < thresh) begin
            rel_map_next = rel_map | sus_map;
            sus_map_next = '0;
          end
          pedal_next = new_pedal;
        end else if (msg_in_range) begin
          if (kind == mnet_pkg::KIND_NOTE_OFF) begin
            if (pedal < thresh) begin
              rel_map_next[msg_idx] = 1'b1;
            end else begin
              sus_map_next[msg_idx] = 1'b1;
            end
          end else if (kind == mnet_pkg::KIND_NOTE_ON) begin
            mem_we                  = 1'b1;
            vel_valid_next[msg_idx] = 1'b1;
          end
        end
      end else begin
        if (cnt[0]) begin
          pb1_next = midi_byte;
        end else begin
          pb0_next = midi_byte;
        end
        cnt_next = cnt + 2'd1;
      end
    end

    if (cmd.rd_done && rd_in_range) begin
      if (vel_valid[rd_idx]) begin
        rd_vel = rd_q;
      end
      if (rd_vel != '0) begin
        vel_valid_next[rd_idx] = 1'b0;
      end else if (rel_map[rd_idx]) begin
        rd_rel                = 1'b1;
        rel_map_next[rd_idx]  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt         <= 2'd0;
      last_status <= '0;
      pedal       <= '0;
      thresh      <= mnet_pkg::THRESH_RESET;
      rel_map     <= '0;
      sus_map     <= '0;
      vel_valid   <= '0;
    end else begin
      cnt         <= cnt_next;
      last_status <= last_status_next;
      pedal       <= pedal_next;
      rel_map     <= rel_map_next;
      sus_map     <= sus_map_next;
      vel_valid   <= vel_valid_next;
      if (cfg_we) begin
        thresh <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    pb0 <= pb0_next;
    pb1 <= pb1_next;
    if (cmd.rd_start) begin
      rkey <= key;
    end
    if (cmd.rd_done) begin
      velocity    <= rd_vel;
      released    <= rd_rel;
      pedal_level <= pedal;
    end
  end

  // velocity store, registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      vel_mem[mem_wa] <= mem_wd;
    end
    if (cmd.rd_start) begin
      rd_q <= vel_mem[key[KW-1:0]];
    end
  end

endmodule

`default_nettype wire

[rtl/core/midi_note_event_tracker.sv]
// Top level of the MIDI note event tracker: controller plus datapath.
// Depends on mnet_pkg, mnet_ctrl and mnet_dp.
//
//  channel  dir  handshake          payload
//  s_*      in   tvalid/tready      tdata: midi_byte[7:0], key[14:8]; tuser: action
//  m_*      out  tvalid/tready      tdata: velocity[6:0], pedal_level[13:7]; tuser: released
//  cfg_*    in   cfg_we             cfg_wdata: sustain_threshold
//
// Bytes can be accepted every cycle, except while the input waits as below.
// A key read passes through the registered read of the velocity memory and
// then the output register, which raises m_tvalid; no further input is taken
// until the read resolves. The result sits in an output register; any input
// waits while a prior result is held and not taken, and during the lookup
// state of a read. Reset is synchronous; all maps clear at once.
`default_nettype none

module midi_note_event_tracker #(
  parameter int NUM_KEYS = mnet_pkg::NUM_KEYS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [6:0]  cfg_wdata,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // midi_byte[7:0], key[14:8], zero pad
  input  wire logic [0:0]  s_tuser,   // action
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // velocity[6:0], pedal_level[13:7], zero pad
  output logic [0:0]       m_tuser    // released
);

  mnet_pkg::mnet_cmd_t cmd;
  logic [mnet_pkg::VEL_W-1:0] velocity;
  logic [mnet_pkg::VEL_W-1:0] pedal_level;
  logic                       released;

  mnet_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .action   (s_tuser[0]),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  mnet_dp #(
    .NUM_KEYS (NUM_KEYS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .midi_byte   (s_tdata[7:0]),
    .key         (s_tdata[14:8]),
    .velocity    (velocity),
    .released    (released),
    .pedal_level (pedal_level)
  );

  assign m_tdata = {2'b00, pedal_level, velocity};
  assign m_tuser = released;

endmodule

`default_nettype wire

[rtl/core/mnet_checker.sv]
// Port-level checks for the MIDI note event tracker, bound to the top level.
// Depends on mnet_pkg and midi_note_event_tracker.
`default_nettype none

module mnet_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic [0:0]  s_tuser,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [15:0] m_tdata,
  input wire logic [0:0]  m_tuser
);

  logic rd_xfer;
  logic byte_xfer;

  assign rd_xfer   = s_tvalid && s_tready && (s_tuser[0] == mnet_pkg::ACT_READ);
  assign byte_xfer = s_tvalid && s_tready && (s_tuser[0] == mnet_pkg::ACT_BYTE);

  // result holds until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped before transfer");

  // a read yields its result: m_tvalid low during the lookup state, then high
  a_rd_lat: assert property (@(posedge clk) disable iff (rst)
    rd_xfer |=> !m_tvalid ##1 m_tvalid)
    else $error("read result timing wrong");

  // controller is busy while the read resolves
  a_rd_busy: assert property (@(posedge clk) disable iff (rst)
    rd_xfer |=> !s_tready)
    else $error("input taken during read");

  // MIDI bytes never produce a result
  a_byte_quiet: assert property (@(posedge clk) disable iff (rst)
    byte_xfer && !m_tvalid |=> !m_tvalid)
    else $error("result from a MIDI byte");

  // a release is only reported with no velocity
  a_rel_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[6:0] == 7'd0)
    else $error("release reported with velocity");

endmodule

bind midi_note_event_tracker mnet_checker u_chk (.*);

`default_nettype wire

[bench/midi_note_event_tracker_tb.sv]
// Self-checking bench for midi_note_event_tracker: directed and random MIDI byte
// and key read traffic, checked against an in-bench model of the key event maps.
// Depends on mnet_pkg and the midi_note_event_tracker RTL.
`default_nettype none

module midi_note_event_tracker_tb;

  localparam int IDLE_PCT     = 34;
  localparam int HOLD_CYCLES  = 400;
  localparam int STALL_LIMIT  = 4000;
  localparam int SETTLE       = 8;
  localparam int DRAIN_CYCLES = 16;
  // first message kind above note on (0xA..0xF; of these the block acts only on 0xB)
  localparam logic [3:0] KIND_POLY_PRESSURE = 4'hA;

  typedef struct {
    logic [6:0] key;
    logic [6:0] velocity;
    logic       released;
    logic [6:0] pedal;
  } key_event_t;

  logic        clk;
  logic        rst       = 1'b1;
  logic        cfg_we    = 1'b0;
  logic [6:0]  cfg_wdata = '0;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata   = '0;
  logic [0:0]  s_tuser   = '0;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [15:0] m_tdata;
  logic [0:0]  m_tuser;

  midi_note_event_tracker dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // model of the tracker state
  logic [6:0] vel_map [128];
  logic       rel_map [128];
  logic       sus_map [128];
  logic [6:0] pedal_lvl   = '0;
  logic [7:0] prev_status = '0;
  logic [1:0] byte_count  = '0;
  logic [7:0] msg_bytes [2];
  logic [6:0] thresh      = mnet_pkg::THRESH_RESET;

  key_event_t expected_events [$];

  bit sender_calm   = 1'b0;
  bit receiver_calm = 1'b0;
  int hold_asked    = 0;
  int hold_served   = 0;
  int hold_left     = 0;
  int errors        = 0;
  int n_bytes       = 0;
  int n_reads       = 0;
  int n_checked     = 0;
  int n_cfg         = 0;
  int stall_cycles  = 0;

  initial begin
    for (int i = 0; i < 128; i++) begin
      vel_map[i] = '0;
      rel_map[i] = 1'b0;
      sus_map[i] = 1'b0;
    end
  end

  function automatic logic [6:0] clamp7(input logic [7:0] v);
    return v[7] ? 7'h7f : v[6:0];
  endfunction

  task automatic apply_message(input logic [7:0] st, input logic [7:0] kb,
                               input logic [7:0] val);
    logic [6:0] nv;
    prev_status = st;
    if (st[7:4] == mnet_pkg::KIND_CONTROL) begin
      nv = clamp7(val);
      // pedal let go: sustained keys turn into releases
      if (pedal_lvl >= thresh && nv < thresh) begin
        for (int i = 0; i < 128; i++) begin
          rel_map[i] = rel_map[i] | sus_map[i];
          sus_map[i] = 1'b0;
        end
      end
      pedal_lvl = nv;
    end else if (!kb[7]) begin
      if (st[7:4] == mnet_pkg::KIND_NOTE_OFF) begin
        if (pedal_lvl < thresh) rel_map[kb[6:0]] = 1'b1;
        else sus_map[kb[6:0]] = 1'b1;
      end else if (st[7:4] == mnet_pkg::KIND_NOTE_ON) begin
        vel_map[kb[6:0]] = clamp7(val);
      end
    end
  endtask

  task automatic take_midi_byte(input logic [7:0] b);
    if (byte_count == 2'd0 && !b[7]) begin
      // running status
      msg_bytes[0] = prev_status;
      msg_bytes[1] = b;
      byte_count = 2'd2;
    end else if (byte_count >= 2'd2) begin
      byte_count = 2'd0;
      apply_message(msg_bytes[0], msg_bytes[1], b);
    end else begin
      msg_bytes[byte_count[0]] = b;
      byte_count = byte_count + 2'd1;
    end
  endtask

  task automatic read_key(input logic [6:0] k);
    key_event_t ev;
    ev.key = k;
    ev.velocity = '0;
    ev.released = 1'b0;
    if (vel_map[k] != '0) begin
      ev.velocity = vel_map[k];
      vel_map[k] = '0;
    end else if (rel_map[k]) begin
      ev.released = 1'b1;
      rel_map[k] = 1'b0;
    end
    ev.pedal = pedal_lvl;
    expected_events = {expected_events, ev};
  endtask

  // one input transfer; s_tvalid stays up afterwards so back-to-back items need no gap
  task automatic send_item(input logic act, input logic [7:0] b, input logic [6:0] k);
    while (!sender_calm && $urandom_range(0, 99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {1'b0, k, b};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (act == mnet_pkg::ACT_BYTE) begin
      take_midi_byte(b);
      n_bytes++;
    end else begin
      read_key(k);
      n_reads++;
    end
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_item(mnet_pkg::ACT_BYTE, b, 7'($urandom_range(0, 127)));
  endtask

  task automatic send_read(input logic [6:0] k);
    send_item(mnet_pkg::ACT_READ, 8'($urandom_range(0, 255)), k);
  endtask

  task automatic set_threshold(input logic [6:0] v);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_events.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    thresh = v;
    n_cfg++;
  endtask

  function automatic logic [6:0] pick_key(input int base);
    if ($urandom_range(0, 3) == 0) return 7'($urandom_range(0, 127));
    return 7'(base + int'($urandom_range(0, 7)));
  endfunction

  function automatic logic [7:0] pick_value(input logic [3:0] kind);
    int lvl;
    if (kind == mnet_pkg::KIND_CONTROL) begin
      case ($urandom_range(0, 4))
        0, 1: begin
          // hover around the threshold
          lvl = int'(thresh) + int'($urandom_range(0, 4)) - 2;
          if (lvl < 0) lvl = 0;
          if (lvl > 127) lvl = 127;
          return 8'(lvl);
        end
        2: return 8'h00;
        3: return 8'h7f;
        default: return 8'($urandom_range(0, 255));
      endcase
    end
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'($urandom_range(128, 255));
      default: return 8'($urandom_range(1, 127));
    endcase
  endfunction

  // mostly well-formed messages on a small key pool, some reads, some junk bytes
  task automatic test_random_traffic(input int n_items);
    int sent;
    int pick;
    int base;
    logic [3:0] kind;
    logic [7:0] kb;
    logic [7:0] val;
    sent = 0;
    base = $urandom_range(0, 120);
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 22) begin
        send_read(pick_key(base));
        sent++;
      end else if (pick < 88) begin
        pick = $urandom_range(0, 9);
        if (pick < 3) kind = mnet_pkg::KIND_NOTE_ON;
        else if (pick < 6) kind = mnet_pkg::KIND_NOTE_OFF;
        else if (pick < 8) kind = mnet_pkg::KIND_CONTROL;
        else kind = KIND_POLY_PRESSURE + 4'($urandom_range(0, 5));
        kb = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(128, 255))
                                            : {1'b0, pick_key(base)};
        if (byte_count == 2'd0 && prev_status[7] && $urandom_range(0, 2) == 0) begin
          send_byte({1'b0, kb[6:0]});
          send_byte(pick_value(prev_status[7:4]));
          sent += 2;
        end else begin
          val = pick_value(kind);
          send_byte({kind, 4'($urandom_range(0, 15))});
          send_byte(kb);
          send_byte(val);
          sent += 3;
        end
      end else begin
        repeat ($urandom_range(1, 3)) begin
          send_byte(8'($urandom_range(0, 255)));
          sent++;
        end
      end
    end
  endtask

  // data bytes before any status byte run with status zero and do nothing
  task automatic test_orphan_data_bytes;
    send_byte(8'h05);
    send_byte(8'h40);
    send_read(7'd5);
  endtask

  task automatic test_note_on_off;
    send_byte({mnet_pkg::KIND_NOTE_ON, 4'h0});
    send_byte(8'h00);
    send_byte(8'hff);            // value above 127 saturates
    send_byte(8'h7f);            // running status note on, top key
    send_byte(8'h01);
    send_byte({mnet_pkg::KIND_NOTE_OFF, 4'h0});
    send_byte(8'h7f);
    send_byte(8'h00);
    send_read(7'd0);
    send_read(7'd127);           // velocity wins, release stays pending
    send_read(7'd127);
  endtask

  task automatic test_sustain_pedal;
    send_byte({mnet_pkg::KIND_CONTROL, 4'h3});
    send_byte(8'h40);
    send_byte(8'h80);
    send_byte({mnet_pkg::KIND_NOTE_OFF, 4'h5});
    send_byte(8'h10);
    send_byte(8'h00);
    send_read(7'd16);
    send_byte({mnet_pkg::KIND_CONTROL, 4'h0});
    send_byte(8'h40);
    send_byte(8'h3f);            // pedal drops below threshold
    send_read(7'd16);
  endtask

  task automatic test_stray_bytes;
    send_byte({mnet_pkg::KIND_NOTE_ON, 4'h0});
    send_byte({mnet_pkg::KIND_NOTE_ON, 4'h0}); // status inside a message: key above 127
    send_byte(8'h10);
    send_byte(8'h10);            // running note on with velocity zero
    send_byte(8'h00);
    send_read(7'd16);
  endtask

  task automatic test_calm_stretch;
    set_threshold(7'($urandom_range(1, 126)));
    sender_calm   = 1'b1;
    receiver_calm = 1'b1;
    test_random_traffic(300);
    sender_calm   = 1'b0;
    receiver_calm = 1'b0;
  endtask

  // receiver stops for a long stretch while reads keep coming
  task automatic test_output_backpressure;
    hold_asked++;
    test_random_traffic(120);
  endtask

  always @(posedge clk) begin : result_side
    key_event_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_events.size() == 0) begin
        $display("%0t: result with none expected: velocity %0d released %0d pedal %0d",
                 $time, m_tdata[6:0], m_tuser[0], m_tdata[13:7]);
        errors++;
      end else begin
        want = expected_events.pop_front();
        n_checked++;
        if (m_tdata[6:0] !== want.velocity) begin
          $display("%0t: key %0d velocity expected %0d actual %0d",
                   $time, want.key, want.velocity, m_tdata[6:0]);
          errors++;
        end
        if (m_tuser[0] !== want.released) begin
          $display("%0t: key %0d released expected %0d actual %0d",
                   $time, want.key, want.released, m_tuser[0]);
          errors++;
        end
        if (m_tdata[13:7] !== want.pedal) begin
          $display("%0t: key %0d pedal_level expected %0d actual %0d",
                   $time, want.key, want.pedal, m_tdata[13:7]);
          errors++;
        end
      end
    end
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left--;
    end else if (hold_served != hold_asked) begin
      hold_served = hold_asked;
      hold_left = HOLD_CYCLES;
      m_tready <= 1'b0;
    end else begin
      m_tready <= receiver_calm ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                 $time, stall_cycles, expected_events.size());
        $display("midi_note_event_tracker verification failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_orphan_data_bytes;
    test_note_on_off;
    test_sustain_pedal;
    test_stray_bytes;
    set_threshold(7'd127);
    test_random_traffic(300);
    set_threshold(7'd0);
    test_random_traffic(300);
    test_calm_stretch;
    test_output_backpressure;
    repeat (3) begin
      set_threshold(7'($urandom_range(0, 127)));
      test_random_traffic(300);
    end
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d MIDI bytes and %0d key reads, %0d results checked,",
             n_bytes, n_reads, n_checked);
    $display("over %0d threshold settings; %0d mismatches", n_cfg + 1, errors);
    if (errors == 0) begin
      $display("midi_note_event_tracker verification clean");
    end else begin
      $display("midi_note_event_tracker verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
